>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master bit engine modules.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_ACK      = 3'd4;
    localparam logic [2:0] OP_NACK     = 3'd5;
    localparam logic [2:0] OP_WAIT_ACK = 3'd6;

    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] UNIT_TICKS_RESET  = 16'd1;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [2:0] UNITS_LONG  = 3'd4;
    localparam logic [2:0] UNITS_BIT   = 3'd2;
    localparam logic [2:0] UNITS_SHORT = 3'd1;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } res_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ,
        CMD_ACK,
        CMD_NACK,
        CMD_WAIT_ACK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] tx_byte;
        logic       sda_in;
    } q_entry_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_WA_A,
        PH_WA_B,
        PH_WA_POLL,
        PH_AK_A,
        PH_AK_B,
        PH_WR_A,
        PH_WR_B,
        PH_WR_C,
        PH_RD_A,
        PH_RD_B
    } phase_t;

endpackage

>>> rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick transactions, decodes the command and queues them for the
// bit engine.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  item_t    item,
    input  logic     pop,
    output logic     q_empty,
    output q_entry_t q_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    q_entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    q_entry_t             entry;
    logic                 push;

    always_comb
    begin
        entry.tx_byte = item.tx_byte;
        entry.sda_in  = item.sda_in;
        entry.kind    = CMD_NONE;
        if (item.cmd_valid)
        begin
            unique case (item.operation)
                OP_START:    entry.kind = CMD_START;
                OP_STOP:     entry.kind = CMD_STOP;
                OP_WRITE:    entry.kind = CMD_WRITE;
                OP_READ:     entry.kind = CMD_READ;
                OP_ACK:      entry.kind = CMD_ACK;
                OP_NACK:     entry.kind = CMD_NACK;
                OP_WAIT_ACK: entry.kind = CMD_WAIT_ACK;
                default:     entry.kind = CMD_NONE;
            endcase
        end
    end

    assign item_ready = (count_reg != FULL_CNT);
    assign push       = item_valid && item_ready;
    assign q_empty    = (count_reg == '0);
    assign q_head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

>>> rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bit engine: steps the SCL/SDA sequencer one tick per queued transaction and
// registers the line levels and status as the result transaction.
// ----------------------------------------------------------------------------
module i2cm_core import i2cm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_empty,
    input  q_entry_t    q_head,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [15:0] unit_count_reg, unit_count_next;
    logic [2:0]  delay_units_reg, delay_units_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic [7:0]  recv_byte_reg, recv_byte_next;
    logic        fail_reg, fail_next;
    logic        done;

    logic        res_valid_reg;
    res_t        res_reg;

    logic [15:0] ut;
    logic [15:0] uc_inc;
    logic [2:0]  dly_dec;
    logic        unit_end;
    logic        delay_end;
    logic [3:0]  bit_inc;

    assign pop       = !q_empty && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        ut        = (unit_ticks_reg == '0) ? 16'd1 : unit_ticks_reg;
        uc_inc    = unit_count_reg + 16'd1;
        unit_end  = (uc_inc >= ut);
        dly_dec   = (delay_units_reg != '0) ? delay_units_reg - 3'd1 : delay_units_reg;
        delay_end = unit_end && (dly_dec == '0);
        bit_inc   = bit_count_reg + 4'd1;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        unit_count_next  = unit_count_reg;
        delay_units_next = delay_units_reg;
        shift_next       = shift_reg;
        poll_count_next  = poll_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        drive_next       = drive_reg;
        recv_byte_next   = recv_byte_reg;
        fail_next        = fail_reg;
        done             = 1'b0;

        if (pop)
        begin
            priority if (phase_reg == PH_IDLE)
            begin
                unit_count_next = '0;
                unique case (q_head.kind)
                    CMD_START:
                    begin
                        drive_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                        phase_next = PH_ST_A; delay_units_next = UNITS_LONG;
                    end
                    CMD_STOP:
                    begin
                        drive_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                        phase_next = PH_SP_A; delay_units_next = UNITS_LONG;
                    end
                    CMD_WRITE:
                    begin
                        drive_next = 1'b1; scl_next = 1'b0;
                        bit_count_next = '0;
                        sda_next   = q_head.tx_byte[7];
                        shift_next = {q_head.tx_byte[6:0], 1'b0};
                        phase_next = PH_WR_A; delay_units_next = UNITS_BIT;
                    end
                    CMD_READ:
                    begin
                        drive_next = 1'b0; scl_next = 1'b0;
                        shift_next = '0; bit_count_next = '0;
                        phase_next = PH_RD_A; delay_units_next = UNITS_BIT;
                    end
                    CMD_ACK, CMD_NACK:
                    begin
                        scl_next = 1'b0; drive_next = 1'b1;
                        sda_next = (q_head.kind == CMD_NACK);
                        phase_next = PH_AK_A; delay_units_next = UNITS_BIT;
                    end
                    CMD_WAIT_ACK:
                    begin
                        drive_next = 1'b0; sda_next = 1'b1;
                        fail_next = 1'b0; poll_count_next = '0;
                        phase_next = PH_WA_A; delay_units_next = UNITS_SHORT;
                    end
                    default:
                    begin
                        unit_count_next = unit_count_reg;
                    end
                endcase
            end
            else if (phase_reg == PH_WA_POLL)
            begin
                priority if (!q_head.sda_in)
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else if (poll_count_reg >= ack_timeout_reg)
                begin
                    fail_next  = 1'b1;
                    drive_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next = PH_SP_A; delay_units_next = UNITS_LONG;
                    unit_count_next = '0;
                end
                else
                begin
                    poll_count_next = poll_count_reg + 8'd1;
                end
            end
            else
            begin
                unit_count_next  = unit_end ? 16'd0 : uc_inc;
                delay_units_next = unit_end ? dly_dec : delay_units_reg;
                if (delay_end)
                begin
                    unique case (phase_reg)
                        PH_ST_A:
                        begin
                            sda_next = 1'b0;
                            phase_next = PH_ST_B; delay_units_next = UNITS_LONG;
                        end
                        PH_ST_B:
                        begin
                            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_SP_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_SP_B; delay_units_next = UNITS_SHORT;
                        end
                        PH_SP_B:
                        begin
                            sda_next = 1'b1;
                            phase_next = PH_SP_C; delay_units_next = UNITS_LONG;
                        end
                        PH_SP_C:
                        begin
                            phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_WA_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_WA_B; delay_units_next = UNITS_SHORT;
                        end
                        PH_WA_B:
                        begin
                            phase_next = PH_WA_POLL;
                        end
                        PH_AK_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_AK_B; delay_units_next = UNITS_BIT;
                        end
                        PH_AK_B:
                        begin
                            scl_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
                        end
                        PH_WR_A:
                        begin
                            scl_next = 1'b1;
                            phase_next = PH_WR_B; delay_units_next = UNITS_BIT;
                        end
                        PH_WR_B:
                        begin
                            scl_next = 1'b0;
                            phase_next = PH_WR_C; delay_units_next = UNITS_BIT;
                        end
                        PH_WR_C:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE)
                            begin
                                phase_next = PH_IDLE; done = 1'b1;
                            end
                            else
                            begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                phase_next = PH_WR_A; delay_units_next = UNITS_BIT;
                            end
                        end
                        PH_RD_A:
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], q_head.sda_in};
                            phase_next = PH_RD_B; delay_units_next = UNITS_SHORT;
                        end
                        PH_RD_B:
                        begin
                            bit_count_next = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE)
                            begin
                                recv_byte_next = shift_reg;
                                phase_next = PH_IDLE; done = 1'b1;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                                phase_next = PH_RD_A; delay_units_next = UNITS_BIT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_UNIT_TICKS)
            begin
                unit_ticks_reg <= cfg_data;
            end
            if (cfg_index == CFG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            unit_count_reg  <= '0;
            delay_units_reg <= '0;
            shift_reg       <= '0;
            poll_count_reg  <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            drive_reg       <= 1'b1;
            recv_byte_reg   <= '0;
            fail_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            unit_count_reg  <= unit_count_next;
            delay_units_reg <= delay_units_next;
            shift_reg       <= shift_next;
            poll_count_reg  <= poll_count_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            drive_reg       <= drive_next;
            recv_byte_reg   <= recv_byte_next;
            fail_reg        <= fail_next;
            if (pop)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg.scl_level  <= scl_next;
            res_reg.sda_level  <= sda_next;
            res_reg.sda_drive  <= drive_next;
            res_reg.ready_res  <= (phase_next == PH_IDLE);
            res_reg.done_res   <= done;
            res_reg.rx_byte    <= recv_byte_next;
            res_reg.ack_failed <= fail_next;
        end
    end

endmodule

>>> rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: one tick transaction in, one line-level result out.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the result side accepts, set by the single-step bit engine.
// Path: an accepted transaction is registered in the tick queue, then popped
//   into the result register once the result side can take it; it also
//   waits behind every entry queued before it.
// Reset: async active low; lines idle high and driven, queue empty,
//   unit_ticks = 1, ack_timeout_polls = 250.
module i2c_master_bit_engine import i2cm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic     pop;
    logic     q_empty;
    q_entry_t q_head;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pop        (pop),
        .q_empty    (q_empty),
        .q_head     (q_head)
    );

    i2cm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty tick queue");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_valid)
        else $error("popped tick produced no result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.done_res) |-> res.ready_res)
        else $error("command done while engine not idle");

endmodule

>>> tb/sv/i2c_master_bit_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_checker
// Watches the tick and line-level channels of the bit engine, predicts every
// line-level transaction from its own copy of the engine state and compares
// it field by field; mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker import i2cm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        res_valid,
    input  logic        res_ready,
    input  res_t        res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        wrap_up,
    output int          fail_count
);

    localparam int PRINT_CAP = 40;

    logic [15:0] unit_ticks;
    logic [7:0]  ack_polls;

    phase_t      phase;
    logic [3:0]  bit_cnt;
    logic [15:0] tick_cnt;
    logic [2:0]  units_left;
    logic [7:0]  shifter;
    logic [7:0]  polls;
    logic        scl_q;
    logic        sda_q;
    logic        drv_q;
    logic [7:0]  rx_q;
    logic        fail_q;

    res_t        expected_lines [$];
    res_t        want;
    int          res_idx;
    int          fail_total;

    assign fail_count = fail_total;

    task automatic report_fault(input string msg);
        if (fail_total < PRINT_CAP)
            $display("[%0t] checker: %s", $realtime, msg);
        fail_total++;
    endtask

    function automatic void load_delay(input phase_t nxt, input logic [2:0] units);
        phase      = nxt;
        units_left = units;
        tick_cnt   = 16'd0;
    endfunction

    function automatic logic unit_elapsed();
        logic [15:0] span;
        span     = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt < span)
            return 1'b0;
        tick_cnt = 16'd0;
        if (units_left != 3'd0)
            units_left = units_left - 3'd1;
        return (units_left == 3'd0);
    endfunction

    function automatic void shift_out_bit();
        sda_q   = shifter[7];
        shifter = {shifter[6:0], 1'b0};
    endfunction

    function automatic res_t line_step(input item_t it);
        res_t r;
        logic fin;
        fin = 1'b0;
        if (phase == PH_IDLE)
        begin
            if (it.cmd_valid)
            begin
                case (it.operation)
                    OP_START:
                    begin
                        drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                        load_delay(PH_ST_A, UNITS_LONG);
                    end
                    OP_STOP:
                    begin
                        drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
                        load_delay(PH_SP_A, UNITS_LONG);
                    end
                    OP_WRITE:
                    begin
                        drv_q = 1'b1; scl_q = 1'b0;
                        shifter = it.tx_byte; bit_cnt = 4'd0;
                        shift_out_bit();
                        load_delay(PH_WR_A, UNITS_BIT);
                    end
                    OP_READ:
                    begin
                        drv_q = 1'b0; scl_q = 1'b0;
                        shifter = 8'd0; bit_cnt = 4'd0;
                        load_delay(PH_RD_A, UNITS_BIT);
                    end
                    OP_ACK, OP_NACK:
                    begin
                        scl_q = 1'b0; drv_q = 1'b1;
                        sda_q = (it.operation == OP_NACK);
                        load_delay(PH_AK_A, UNITS_BIT);
                    end
                    OP_WAIT_ACK:
                    begin
                        drv_q = 1'b0; sda_q = 1'b1;
                        fail_q = 1'b0; polls = 8'd0;
                        load_delay(PH_WA_A, UNITS_SHORT);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (phase == PH_WA_POLL)
        begin
            if (!it.sda_in)
            begin
                scl_q = 1'b0;
                phase = PH_IDLE;
                fin   = 1'b1;
            end
            else if (polls >= ack_polls)
            begin
                // timeout: flag at once, then release the bus with a stop
                fail_q = 1'b1;
                drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
                load_delay(PH_SP_A, UNITS_LONG);
            end
            else
                polls = polls + 8'd1;
        end
        else if (unit_elapsed())
        begin
            case (phase)
                PH_ST_A:
                begin
                    sda_q = 1'b0;
                    load_delay(PH_ST_B, UNITS_LONG);
                end
                PH_ST_B:
                begin
                    scl_q = 1'b0; phase = PH_IDLE; fin = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_q = 1'b1;
                    load_delay(PH_SP_B, UNITS_SHORT);
                end
                PH_SP_B:
                begin
                    sda_q = 1'b1;
                    load_delay(PH_SP_C, UNITS_LONG);
                end
                PH_SP_C:
                begin
                    phase = PH_IDLE; fin = 1'b1;
                end
                PH_WA_A:
                begin
                    scl_q = 1'b1;
                    load_delay(PH_WA_B, UNITS_SHORT);
                end
                PH_WA_B:
                    phase = PH_WA_POLL;
                PH_AK_A:
                begin
                    scl_q = 1'b1;
                    load_delay(PH_AK_B, UNITS_BIT);
                end
                PH_AK_B:
                begin
                    scl_q = 1'b0; phase = PH_IDLE; fin = 1'b1;
                end
                PH_WR_A:
                begin
                    scl_q = 1'b1;
                    load_delay(PH_WR_B, UNITS_BIT);
                end
                PH_WR_B:
                begin
                    scl_q = 1'b0;
                    load_delay(PH_WR_C, UNITS_BIT);
                end
                PH_WR_C:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        phase = PH_IDLE; fin = 1'b1;
                    end
                    else
                    begin
                        shift_out_bit();
                        load_delay(PH_WR_A, UNITS_BIT);
                    end
                end
                PH_RD_A:
                begin
                    scl_q   = 1'b1;
                    shifter = {shifter[6:0], it.sda_in};
                    load_delay(PH_RD_B, UNITS_SHORT);
                end
                PH_RD_B:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE)
                    begin
                        rx_q = shifter; phase = PH_IDLE; fin = 1'b1;
                    end
                    else
                    begin
                        scl_q = 1'b0;
                        load_delay(PH_RD_A, UNITS_BIT);
                    end
                end
                default:
                    phase = PH_IDLE;
            endcase
        end
        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_drive  = drv_q;
        r.ready_res  = (phase == PH_IDLE);
        r.done_res   = fin;
        r.rx_byte    = rx_q;
        r.ack_failed = fail_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks = UNIT_TICKS_RESET;
            ack_polls  = ACK_TIMEOUT_RESET;
            phase      = PH_IDLE;
            bit_cnt    = 4'd0;
            tick_cnt   = 16'd0;
            units_left = 3'd0;
            shifter    = 8'd0;
            polls      = 8'd0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            drv_q      = 1'b1;
            rx_q       = 8'd0;
            fail_q     = 1'b0;
            res_idx    = 0;
            fail_total = 0;
            expected_lines.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_UNIT_TICKS)
                    unit_ticks = cfg_data;
                else
                    ack_polls = cfg_data[7:0];
            end
            if (res_valid && res_ready)
            begin
                if (expected_lines.size() == 0)
                    report_fault($sformatf("result %0d arrived with nothing expected",
                                           res_idx));
                else
                begin
                    want = expected_lines.pop_front();
                    if (res.scl_level !== want.scl_level)
                        report_fault($sformatf("result %0d scl_level %0b want %0b",
                                               res_idx, res.scl_level, want.scl_level));
                    if (res.sda_level !== want.sda_level)
                        report_fault($sformatf("result %0d sda_level %0b want %0b",
                                               res_idx, res.sda_level, want.sda_level));
                    if (res.sda_drive !== want.sda_drive)
                        report_fault($sformatf("result %0d sda_drive %0b want %0b",
                                               res_idx, res.sda_drive, want.sda_drive));
                    if (res.ready_res !== want.ready_res)
                        report_fault($sformatf("result %0d ready_res %0b want %0b",
                                               res_idx, res.ready_res, want.ready_res));
                    if (res.done_res !== want.done_res)
                        report_fault($sformatf("result %0d done_res %0b want %0b",
                                               res_idx, res.done_res, want.done_res));
                    if (res.rx_byte !== want.rx_byte)
                        report_fault($sformatf("result %0d rx_byte %02h want %02h",
                                               res_idx, res.rx_byte, want.rx_byte));
                    if (res.ack_failed !== want.ack_failed)
                        report_fault($sformatf("result %0d ack_failed %0b want %0b",
                                               res_idx, res.ack_failed, want.ack_failed));
                end
                res_idx++;
            end
            if (item_valid && item_ready)
                expected_lines.push_back(line_step(item));
            if (wrap_up && expected_lines.size() != 0)
            begin
                report_fault($sformatf("%0d expected results never arrived",
                                       expected_lines.size()));
                expected_lines.delete();
            end
        end
    end

endmodule

>>> tb/sv/i2c_master_bit_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Drives tick transactions into the I2C master bit engine: a directed pass
// over every command and corner, then bus-shaped random traffic under several
// timing settings, with random stalls on both sides. The checker does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam logic [2:0]  OP_UNUSED      = 3'd7;
    localparam int          HALF_PERIOD    = 4;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_AT        = 300;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          SETTLE_CYCLES  = 8;
    // a typical bus transfer, one command per completed one
    localparam logic [23:0] BUS_SCRIPT     = {OP_STOP, OP_NACK, OP_READ, OP_ACK,
                                              OP_READ, OP_WAIT_ACK, OP_WRITE, OP_START};

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        wrap_up;
    logic        quiet;
    int          fail_count;

    int          items_sent;
    int          results_taken;
    int          dones_seen;
    int          stall_cycles;

    i2c_master_bit_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    i2c_master_bit_engine_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .wrap_up    (wrap_up),
        .fail_count (fail_count)
    );

    initial
        clk = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_sent    <= 0;
            results_taken <= 0;
            dones_seen    <= 0;
            stall_cycles  <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                items_sent <= items_sent + 1;
            if (res_valid && res_ready)
            begin
                results_taken <= results_taken + 1;
                if (res.done_res)
                    dones_seen <= dones_seen + 1;
            end
            if ((item_valid && item_ready) || (res_valid && res_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAIL i2c_master_bit_engine");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        bit held_off;
        held_off  = 1'b0;
        res_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_taken >= HOLD_AT)
            begin
                held_off = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_ready <= quiet || ($urandom_range(99) >= 19);
        end
    end

    task automatic send_item(input item_t it);
        while (!quiet && $urandom_range(99) < 19)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (results_taken != items_sent)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] unit, input logic [7:0] poll_limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNIT_TICKS;
        cfg_data  <= unit;
        @(negedge clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= {8'($urandom), poll_limit};
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // one command, then filler ticks; busy fillers offer commands the engine must ignore
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] data, input logic line,
                           input int fill, input logic busy);
        item_t it;
        it.cmd_valid = 1'b1;
        it.operation = op;
        it.tx_byte   = data;
        it.sda_in    = line;
        send_item(it);
        repeat (fill)
        begin
            it.cmd_valid = busy;
            it.operation = 3'($urandom_range(7));
            it.tx_byte   = 8'($urandom);
            send_item(it);
        end
    endtask

    task automatic random_phase(input logic [15:0] unit, input logic [7:0] poll_limit,
                                input int count);
        item_t it;
        int    line_mode;
        drain();
        set_config(unit, poll_limit);
        line_mode = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k % 48 == 0)
                line_mode = $urandom_range(2);
            it.cmd_valid = ($urandom_range(3) == 0);
            if ($urandom_range(7) == 0)
                it.operation = 3'($urandom_range(7));
            else
                it.operation = BUS_SCRIPT[3 * (dones_seen % 8) +: 3];
            it.tx_byte = 8'($urandom);
            case (line_mode)
                0:       it.sda_in = 1'($urandom_range(1));
                1:       it.sda_in = ($urandom_range(63) != 0);
                default: it.sda_in = ($urandom_range(7) == 0);
            endcase
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_UNIT_TICKS;
        cfg_data   = 16'd0;
        wrap_up    = 1'b0;
        quiet      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings
        run_cmd(OP_UNUSED, 8'h00, 1'b1, 2, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b1, 10, 1'b0);
        run_cmd(OP_WRITE, 8'hFF, 1'b1, 50, 1'b0);
        run_cmd(OP_WRITE, 8'h00, 1'b0, 50, 1'b0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 5, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b1, 30, 1'b0);
        run_cmd(OP_READ, 8'h00, 1'b0, 30, 1'b0);
        run_cmd(OP_ACK, 8'h00, 1'b0, 8, 1'b0);
        run_cmd(OP_NACK, 8'h00, 1'b1, 8, 1'b0);
        run_cmd(OP_START, 8'hA5, 1'b0, 5, 1'b1);
        run_cmd(OP_STOP, 8'h00, 1'b1, 14, 1'b0);
        drain();

        // zero unit length and zero poll limit
        set_config(16'd0, 8'd0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b1, 20, 1'b0);
        run_cmd(OP_WAIT_ACK, 8'h00, 1'b0, 6, 1'b0);
        run_cmd(OP_START, 8'h00, 1'b0, 10, 1'b0);

        random_phase(16'd1, 8'd250, 60);
        random_phase(16'd2, 8'd3, 50);
        quiet = 1'b1;
        random_phase(16'd1, 8'd0, 45);
        quiet = 1'b0;
        random_phase(16'd3, 8'd255, 55);
        // a whole unit longer than the phase; next setting cuts the delay short
        random_phase(16'hFFFF, 8'd1, 25);
        random_phase(16'd1, 8'd1, 60);
        random_phase(16'd0, 8'd2, 45);

        drain();
        wrap_up <= 1'b1;
        @(negedge clk);
        wrap_up <= 1'b0;
        @(negedge clk);
        if (fail_count == 0)
            $display("PASS i2c_master_bit_engine");
        else
            $display("FAIL i2c_master_bit_engine");
        $finish;
    end

endmodule
